FILE: sv/smwp_pkg.sv
// smwp_pkg: shared constants, types and register codes for the
// minimal-waste partition block; no dependencies
package smwp_pkg;

  localparam int MAX_LEN     = 256;
  localparam int MAX_SPLITS  = 16;
  localparam int VALUE_BITS  = 20;
  localparam int WASTE_BITS  = 28;
  localparam int SUM_BITS    = 28;
  localparam int K_BITS      = 5;
  localparam int ROW         = MAX_SPLITS + 1;
  localparam int ADDR_BITS   = $clog2(MAX_LEN);
  localparam int CNT_BITS    = $clog2(MAX_LEN + 1);
  localparam int DP_DEPTH    = MAX_LEN * ROW;
  localparam int DP_AW       = $clog2(DP_DEPTH);
  localparam int PROD_BITS   = CNT_BITS + VALUE_BITS;
  localparam int BASE_BITS   = SUM_BITS + 2;
  localparam int CAND_BITS   = BASE_BITS + 1;

  // configuration register index decoded from paddr[2]
  localparam logic REG_MAX_CHANGES = 1'b0;

  // one stored element with its running prefix data
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [SUM_BITS-1:0]   incl;   // sum of elements up to and including this one
    logic [VALUE_BITS-1:0] pmax;   // max of elements up to and including this one
  } elem_word_t;

  // request to the shared multiply-add unit: base + len * peak
  typedef struct packed {
    logic [CNT_BITS-1:0]         len;
    logic [VALUE_BITS-1:0]       peak;
    logic signed [BASE_BITS-1:0] base;
  } mac_req_t;

endpackage

FILE: sv/smwp_if.sv
// smwp_if: valid/ready channel interfaces for input and result words
// depends on smwp_pkg
interface smwp_in_if;
  import smwp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] size_value;
  logic                  is_last;

  modport source (output valid, size_value, is_last, input ready);
  modport sink (input valid, size_value, is_last, output ready);
endinterface

interface smwp_out_if;
  import smwp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WASTE_BITS-1:0] min_waste;

  modport source (output valid, min_waste, input ready);
  modport sink (input valid, min_waste, output ready);
endinterface

FILE: sv/segment_max_waste_partition_dp.sv
// segment_max_waste_partition_dp: load a sequence, then find the minimal
// waste partition with at most K+1 segments through one shared multiply-add unit.
// Loading takes one word per cycle. After the last word each row steps through the
// read, data, M1, M2 and finish states, each split candidate through read, data, M1,
// M2 and compare. Input is not ready meanwhile, nor while a solve waits in S_DONE.
// Synchronous active-low reset clears control state and sets max_changes to 0.
module segment_max_waste_partition_dp
  import smwp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  smwp_in_if.sink           in_ch,
  smwp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_ROW_RD  = 4'd1;
  localparam logic [3:0] S_ROW_DAT = 4'd2;
  localparam logic [3:0] S_ROW_M1  = 4'd3;
  localparam logic [3:0] S_ROW_M2  = 4'd4;
  localparam logic [3:0] S_ROW_FIN = 4'd5;
  localparam logic [3:0] S_K_RD    = 4'd6;
  localparam logic [3:0] S_K_DAT   = 4'd7;
  localparam logic [3:0] S_K_M1    = 4'd8;
  localparam logic [3:0] S_K_M2    = 4'd9;
  localparam logic [3:0] S_K_CMP   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]            state_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [SUM_BITS-1:0]   psum_r;
  logic [VALUE_BITS-1:0] rmax_r;
  logic [CNT_BITS-1:0]   n_r;
  logic [CNT_BITS-1:0]   i_r;
  logic [ADDR_BITS-1:0]  k_r;
  logic [K_BITS-1:0]     j_r;
  logic [K_BITS-1:0]     keff_r;
  logic [SUM_BITS-1:0]   psi_r;
  logic [WASTE_BITS-1:0] prev_r;
  logic [WASTE_BITS-1:0] best_r;
  logic [VALUE_BITS-1:0] peak_r;
  logic                  out_valid_r;
  logic [WASTE_BITS-1:0] out_waste_r;

  logic [K_BITS-1:0]     max_changes;
  logic                  load_fire;
  logic                  load_store;
  logic [SUM_BITS-1:0]   psum_nxt;
  logic [VALUE_BITS-1:0] rmax_nxt;
  elem_word_t            elem_wdata;
  elem_word_t            elem_rd_r;
  logic [ADDR_BITS-1:0]  elem_raddr;
  logic [ADDR_BITS-1:0]  i_m1;
  logic [ADDR_BITS-1:0]  k_m1;
  logic [DP_AW-1:0]      row_base;
  logic [DP_AW-1:0]      dp_raddr;
  logic [DP_AW-1:0]      dp_waddr;
  logic [WASTE_BITS-1:0] dp_wdata;
  logic                  dp_we;
  logic [WASTE_BITS-1:0] dp_rd_r;
  logic [WASTE_BITS-1:0] dp_k;
  logic [SUM_BITS-1:0]   ps_k;
  logic [VALUE_BITS-1:0] peak_nxt;
  mac_req_t              mac_req;
  logic signed [CAND_BITS-1:0] mac_sum;
  logic                  cand_less;
  logic [WASTE_BITS-1:0] best_nxt;
  logic                  last_row;
  logic                  out_free;

  elem_word_t            elem_mem [MAX_LEN];
  logic [WASTE_BITS-1:0] dp_mem [DP_DEPTH];

  smwp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_changes (max_changes)
  );

  smwp_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .sum (mac_sum)
  );

  // channel handshakes
  assign in_ch.ready      = (state_r == S_LOAD);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_waste = out_waste_r;
  assign load_fire        = in_ch.valid && in_ch.ready;
  assign load_store       = load_fire && (cnt_r < CNT_BITS'(MAX_LEN));
  assign out_free         = !out_valid_r || out_ch.ready;

  // running prefix data while loading
  assign psum_nxt   = psum_r + SUM_BITS'(in_ch.size_value);
  assign rmax_nxt   = (in_ch.size_value > rmax_r) ? in_ch.size_value : rmax_r;
  assign elem_wdata = '{value: in_ch.size_value, incl: psum_nxt, pmax: rmax_nxt};

  // table addressing: row r (1..n) lives at (r-1)*ROW, row zero is implicit
  assign i_m1       = ADDR_BITS'(i_r - 1'b1);
  assign k_m1       = k_r - 1'b1;
  assign row_base   = DP_AW'(i_m1) * DP_AW'(ROW);
  assign dp_raddr   = DP_AW'(k_m1) * DP_AW'(ROW) + DP_AW'(j_r - 1'b1);
  assign elem_raddr = (state_r == S_ROW_RD) ? i_m1 : k_r;
  assign last_row   = (i_r == n_r);

  // element memory
  always_ff @(posedge clk) begin
    if (load_store) begin
      elem_mem[cnt_r[ADDR_BITS-1:0]] <= elem_wdata;
    end
    elem_rd_r <= elem_mem[elem_raddr];
  end

  // cost table memory
  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[dp_waddr] <= dp_wdata;
    end
    dp_rd_r <= dp_mem[dp_raddr];
  end

  // candidate operands for split at k
  assign dp_k     = (k_r == '0) ? '0 : dp_rd_r;
  assign ps_k     = elem_rd_r.incl - SUM_BITS'(elem_rd_r.value);
  assign peak_nxt = (elem_rd_r.value > peak_r) ? elem_rd_r.value : peak_r;

  // multiply-add request
  always_comb begin
    mac_req = '0;
    if (state_r == S_ROW_DAT) begin
      mac_req.len  = i_r;
      mac_req.peak = elem_rd_r.pmax;
      mac_req.base = -$signed({2'b00, elem_rd_r.incl});
    end else if (state_r == S_K_DAT) begin
      mac_req.len  = i_r - CNT_BITS'(k_r);
      mac_req.peak = peak_nxt;
      mac_req.base = $signed({2'b00, dp_k}) + $signed({2'b00, ps_k})
                   - $signed({2'b00, psi_r});
    end
  end

  // running minimum
  assign cand_less = mac_sum < $signed({{(CAND_BITS-WASTE_BITS){1'b0}}, best_r});
  assign best_nxt  = cand_less ? mac_sum[WASTE_BITS-1:0] : best_r;

  // table writes
  always_comb begin
    dp_we    = 1'b0;
    dp_waddr = row_base;
    dp_wdata = mac_sum[WASTE_BITS-1:0];
    if (state_r == S_ROW_FIN) begin
      dp_we = 1'b1;
    end else if (state_r == S_K_CMP && k_r == '0) begin
      dp_we    = 1'b1;
      dp_waddr = row_base + DP_AW'(j_r);
      dp_wdata = best_nxt;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      psum_r      <= '0;
      rmax_r      <= '0;
      i_r         <= CNT_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (load_fire && in_ch.is_last) begin
            n_r    <= load_store ? cnt_r + 1'b1 : cnt_r;
            keff_r <= (max_changes > K_BITS'(MAX_SPLITS)) ? K_BITS'(MAX_SPLITS)
                                                          : max_changes;
            cnt_r   <= '0;
            psum_r  <= '0;
            rmax_r  <= '0;
            i_r     <= CNT_BITS'(1);
            state_r <= S_ROW_RD;
          end else if (load_store) begin
            cnt_r  <= cnt_r + 1'b1;
            psum_r <= psum_nxt;
            rmax_r <= rmax_nxt;
          end
        end
        S_ROW_RD:  state_r <= S_ROW_DAT;
        S_ROW_DAT: begin
          psi_r   <= elem_rd_r.incl;
          state_r <= S_ROW_M1;
        end
        S_ROW_M1:  state_r <= S_ROW_M2;
        S_ROW_M2:  state_r <= S_ROW_FIN;
        S_ROW_FIN: begin
          prev_r <= mac_sum[WASTE_BITS-1:0];
          if (keff_r != '0) begin
            j_r     <= K_BITS'(1);
            best_r  <= mac_sum[WASTE_BITS-1:0];
            peak_r  <= '0;
            k_r     <= i_m1;
            state_r <= S_K_RD;
          end else if (last_row) begin
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ROW_RD;
          end
        end
        S_K_RD:  state_r <= S_K_DAT;
        S_K_DAT: begin
          peak_r  <= peak_nxt;
          state_r <= S_K_M1;
        end
        S_K_M1:  state_r <= S_K_M2;
        S_K_M2:  state_r <= S_K_CMP;
        S_K_CMP: begin
          best_r <= best_nxt;
          if (k_r != '0) begin
            k_r     <= k_m1;
            state_r <= S_K_RD;
          end else begin
            prev_r <= best_nxt;
            if (j_r != keff_r) begin
              j_r     <= j_r + 1'b1;
              peak_r  <= '0;
              k_r     <= i_m1;
              state_r <= S_K_RD;
            end else if (last_row) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_ROW_RD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_waste_r <= prev_r;
            out_valid_r <= 1'b1;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // split point stays inside the current prefix
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_DAT) |-> (CNT_BITS'(k_r) < i_r))
    else $error("split index outside prefix");

  // split budget index within the latched budget
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_RD) |-> (j_r != '0 && j_r <= keff_r))
    else $error("split budget index out of range");

  // row counter never passes the loaded length
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && state_r != S_DONE) |-> (i_r != '0 && i_r <= n_r))
    else $error("row index out of range");

  // a result word appears only at the end of a solve
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word without finished solve");

endmodule

FILE: sv/smwp_cfg.sv
// smwp_cfg: APB-style register file holding max_changes
// depends on smwp_pkg
module smwp_cfg
  import smwp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [K_BITS-1:0] max_changes
);

  logic [K_BITS-1:0] max_changes_r;
  logic              wr_en;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite && (paddr[2] == REG_MAX_CHANGES);
  assign max_changes = max_changes_r;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_changes_r <= '0;
    end else if (wr_en) begin
      max_changes_r <= pwdata[K_BITS-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_CHANGES) begin
      prdata = {{(32-K_BITS){1'b0}}, max_changes_r};
    end
  end

endmodule

FILE: sv/smwp_mac.sv
// smwp_mac: shared multiply-add unit, three register stages
// computes base + len * peak; depends on smwp_pkg
module smwp_mac
  import smwp_pkg::*;
(
  input  logic                        clk,
  input  mac_req_t                    req,
  output logic signed [CAND_BITS-1:0] sum
);

  mac_req_t                    req_r;
  logic [PROD_BITS-1:0]        prod_r;
  logic signed [BASE_BITS-1:0] base_r;
  logic signed [CAND_BITS-1:0] sum_r;

  assign sum = sum_r;

  // operand, product and sum stages
  always_ff @(posedge clk) begin
    req_r  <= req;
    prod_r <= req_r.len * req_r.peak;
    base_r <= req_r.base;
    sum_r  <= CAND_BITS'(base_r) + $signed({{(CAND_BITS-PROD_BITS){1'b0}}, prod_r});
  end

endmodule

FILE: test/segment_max_waste_partition_dp_tb.sv
// testbench for segment_max_waste_partition_dp: loads size sequences, predicts the
// minimal partition waste in a scoreboard class and checks every result word
// depends on smwp_pkg, smwp_in_if, smwp_out_if and the block itself
`timescale 1ns / 1ps

module segment_max_waste_partition_dp_tb;
  import smwp_pkg::*;

  localparam logic [2:0] ADDR_MAX_CHANGES = {REG_MAX_CHANGES, 2'b00};
  localparam logic [2:0] ADDR_SPARE       = {~REG_MAX_CHANGES, 2'b00};
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES     = 800;
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int unsigned PHASE_WORDS     = 6;

  // expected waste per loaded sequence, checked in arrival order
  class partition_checker;
    logic [K_BITS-1:0]     budget;
    logic [VALUE_BITS-1:0] loaded[$];
    logic [WASTE_BITS-1:0] waste_due[$];
    int unsigned           mismatches;

    function new();
      budget     = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // least waste over cuts into at most budget+1 segments
    function logic [WASTE_BITS-1:0] min_waste_for();
      int unsigned       n, kb, row, i, j, s;
      longint unsigned   pmax, peak, best, cand;
      longint unsigned   psum[];
      longint unsigned   tbl[];
      n    = loaded.size();
      kb   = (budget > MAX_SPLITS) ? MAX_SPLITS : budget;
      row  = kb + 1;
      psum = new[n + 1];
      tbl  = new[(n + 1) * row];
      psum[0] = 0;
      for (i = 0; i < n; i++) psum[i + 1] = psum[i] + loaded[i];
      for (j = 0; j <= kb; j++) tbl[j] = 0;
      pmax = 0;
      for (i = 1; i <= n; i++) begin
        if (loaded[i - 1] > pmax) pmax = loaded[i - 1];
        tbl[i * row] = longint'(i) * pmax - psum[i];
        for (j = 1; j <= kb; j++) begin
          best = tbl[i * row + j - 1];
          peak = 0;
          // last segment covers elements s-1 .. i-1
          for (s = i; s > 0; s--) begin
            if (loaded[s - 1] > peak) peak = loaded[s - 1];
            cand = tbl[(s - 1) * row + j - 1] + longint'(i - s + 1) * peak
                 - (psum[i] - psum[s - 1]);
            if (cand < best) best = cand;
          end
          tbl[i * row + j] = best;
        end
      end
      return tbl[n * row + kb][WASTE_BITS-1:0];
    endfunction

    // words past the capacity are dropped, the last flag still counts
    function void note_word(input logic [VALUE_BITS-1:0] v, input logic last);
      if (loaded.size() < MAX_LEN) loaded.push_back(v);
      if (last) begin
        waste_due.push_back(min_waste_for());
        loaded.delete();
      end
    endfunction

    task check_waste(input logic [WASTE_BITS-1:0] got);
      logic [WASTE_BITS-1:0] want;
      if (waste_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", got));
      end else begin
        want = waste_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf("min_waste got %0d want %0d", got, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        hold_on = 1'b0;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  partition_checker sb = new();

  smwp_in_if  in_ch ();
  smwp_out_if out_ch ();

  segment_max_waste_partition_dp dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // result side: check accepted words, then choose ready for the next cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_waste(out_ch.min_waste);
      out_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end
  end

  // skewed size: zeros, all ones, small values and full-range values
  function automatic logic [VALUE_BITS-1:0] pick_size();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_BITS'($urandom_range(15));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // offer one word after a random gap, wait for the handshake
  task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic last);
    if (send_pct != 0) begin
      while ($urandom_range(99) < send_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.size_value <= v;
    in_ch.is_last    <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(v, last);
  endtask

  task automatic send_random_sequence(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_word(pick_size(), i == len - 1);
  endtask

  // mostly short sequences, now and then a longer one
  task automatic send_random_phase(input int unsigned words);
    int unsigned sent, len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 24);
      send_random_sequence(len);
      sent += len;
    end
  endtask

  // wait for the block to go idle, write a register, read max_changes back
  task automatic reconfigure(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.waste_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_MAX_CHANGES) sb.budget = data[K_BITS-1:0];
    // read back right after the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_CHANGES;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(sb.budget))
      sb.report_mismatch($sformatf("max_changes read %0h want %0h", rd, sb.budget));
  endtask

  task automatic set_budget(input logic [K_BITS-1:0] changes);
    logic [31:0] wdata;
    wdata = $urandom;
    wdata[K_BITS-1:0] = changes;
    reconfigure(ADDR_MAX_CHANGES, wdata);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.size_value <= '0;
    in_ch.is_last    <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // unmapped address is ignored, max_changes reads its reset value
    reconfigure(ADDR_SPARE, 32'h0000_0007);

    // no changes allowed: one segment
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(20'hAAAAA, 1'b0);
    send_word(20'h55555, 1'b1);

    // one change
    set_budget(5'd1);
    send_word(20'd1, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(20'd7, 1'b1);

    // budget above the split limit and above the length
    set_budget(5'd31);
    send_word(20'd3, 1'b0);
    send_word(20'd9, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(20'd12, 1'b1);

    // budget allows one segment fewer than the length
    set_budget(5'd2);
    send_word(20'd5, 1'b0);
    send_word(20'd1, 1'b0);
    send_word(20'd5, 1'b0);
    send_word(20'd1, 1'b1);

    // random phases with varying budget and idling
    for (int p = 0; p < 11; p++) begin
      case (p)
        0:       set_budget(5'd0);
        1:       set_budget(5'd31);
        2:       set_budget(5'd16);
        3:       set_budget(5'd17);
        4:       set_budget(5'd15);
        default: set_budget(K_BITS'($urandom_range(0, 31)));
      endcase
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 71; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 71; end
        default: begin send_pct = 13; stall_pct = 13; end
      endcase
      send_random_phase(PHASE_WORDS);
    end

    // long receiver hold-off while words keep coming, so the block backs up
    set_budget(5'd2);
    send_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    for (int s = 0; s < 8; s++) send_random_sequence($urandom_range(3, 5));

    // sender waits for every result before the next sequence
    set_budget(K_BITS'($urandom_range(0, 31)));
    send_pct  = 13;
    stall_pct = 13;
    for (int s = 0; s < 8; s++) begin
      send_random_sequence($urandom_range(1, 8));
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (sb.waste_due.size() != 0);
    end

    // sequence longer than the store: tail words and the flagged one dropped
    set_budget(5'd0);
    send_pct  = 0;
    stall_pct = 13;
    send_random_sequence(MAX_LEN + 6);

    // drain and settle
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.waste_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
